### src/lcg48_pkg.sv
// shared types and constants for the 48-bit lcg random generator
package lcg48_pkg;

    // generator constants
    localparam int          SEED_W    = 48;
    localparam int          MULT_W    = 35;
    localparam int          HALF_W    = 32;
    localparam int          LEN_W     = 31;
    localparam int          DATA_W    = 64;
    localparam int          BOOL_BIT  = 30;
    localparam logic [MULT_W-1:0] LCG_MULT  = 35'h5DEECE66D;
    localparam logic [SEED_W-1:0] LCG_INC   = 48'd11;
    localparam logic [SEED_W-1:0] SEED_INIT = 48'd1;

    // stream payload widths
    localparam int          ACT_W     = 3;
    localparam int          IN_DATA_W = 136;

    // request codes
    typedef enum logic [ACT_W-1:0] {
        ACT_INT      = 3'd0,
        ACT_RANGE    = 3'd1,
        ACT_INT64    = 3'd2,
        ACT_BOOL     = 3'd3,
        ACT_SET_SEED = 3'd4,
        ACT_COMBINE  = 3'd5
    } t_action;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RANGE,
        ST_WRITE
    } t_state;

endpackage

### src/lcg48_random_generator_core.sv
// 48-bit lcg random generator with one shared multiplier under a small sequencer
// a request steps ST_MUL_LO and ST_MUL_HI (the pair twice for next_int64 and combine_seed),
// ST_RANGE (next_in_range only), ST_WRITE; set_seed and unused codes go straight to ST_WRITE
// one request at a time: ST_WRITE waits for a free output register, and a new request
// can be taken in the cycle after the result is stored; each lcg step is two passes of the
// 32x35 multiplier, and next_in_range adds one more pass for the scaling product
// reset (synchronous, active low) sets the seed to 1, idles the sequencer, drops tvalid
module lcg48_random_generator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request: action, seed_value, range_start, range_length (lowest bit up)
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [lcg48_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // result: draw_value
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [lcg48_pkg::DATA_W-1:0]       o_m_axis_tdata
);

    localparam int SW = lcg48_pkg::SEED_W;
    localparam int HW = lcg48_pkg::HALF_W;
    localparam int MW = lcg48_pkg::MULT_W;
    localparam int DW = lcg48_pkg::DATA_W;
    localparam int PW = HW + MW;

    // input field unpacking
    logic [lcg48_pkg::ACT_W-1:0]  w_in_action;
    logic [DW-1:0]                w_in_sval;
    logic [HW-1:0]                w_in_start;
    logic [lcg48_pkg::LEN_W-1:0]  w_in_len;
    assign w_in_action = i_s_axis_tdata[2:0];
    assign w_in_sval   = i_s_axis_tdata[66:3];
    assign w_in_start  = i_s_axis_tdata[98:67];
    assign w_in_len    = i_s_axis_tdata[129:99];

    lcg48_pkg::t_state  r_state, n_state;
    lcg48_pkg::t_action r_action;
    logic [SW-1:0]      r_seed;
    logic [DW-1:0]      r_sval;
    logic [HW-1:0]      r_start;
    logic [lcg48_pkg::LEN_W-1:0] r_len;
    logic [SW-1:0]      r_acc;
    logic [HW-1:0]      r_hi;
    logic [HW-1:0]      r_draw;
    logic               r_second;
    logic [DW-1:0]      r_result;
    logic               r_out_valid;
    logic [DW-1:0]      r_out_data;

    logic               w_in_acc;
    logic               w_out_free;
    logic [HW-1:0]      w_mul_a;
    logic [MW-1:0]      w_mul_b;
    logic [PW-1:0]      w_mul_p;
    logic [SW-1:0]      w_seed_step;
    logic [HW-1:0]      w_step_draw;
    logic [HW-1:0]      w_range_sum;
    logic [DW-1:0]      w_draw64;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // shared multiplier
    assign w_mul_p = {{MW{1'b0}}, w_mul_a} * {{HW{1'b0}}, w_mul_b};

    // second half of an lcg step, new draw and helpers
    assign w_seed_step = r_acc + {w_mul_p[SW-HW-1:0], {HW{1'b0}}};
    assign w_step_draw = w_seed_step[SW-1:SW-HW];
    assign w_range_sum = r_start + w_mul_p[2*HW-1:HW];
    assign w_draw64    = {r_hi, w_step_draw};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcg48_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (lcg48_pkg::t_action'(w_in_action))
                        lcg48_pkg::ACT_INT,
                        lcg48_pkg::ACT_RANGE,
                        lcg48_pkg::ACT_INT64,
                        lcg48_pkg::ACT_BOOL,
                        lcg48_pkg::ACT_COMBINE: n_state = lcg48_pkg::ST_MUL_LO;
                        default:                n_state = lcg48_pkg::ST_WRITE;
                    endcase
                end
            end
            lcg48_pkg::ST_MUL_LO: n_state = lcg48_pkg::ST_MUL_HI;
            lcg48_pkg::ST_MUL_HI: begin
                priority if (!r_second && (r_action == lcg48_pkg::ACT_INT64 ||
                                           r_action == lcg48_pkg::ACT_COMBINE)) begin
                    n_state = lcg48_pkg::ST_MUL_LO;
                end else if (r_action == lcg48_pkg::ACT_RANGE) begin
                    n_state = lcg48_pkg::ST_RANGE;
                end else begin
                    n_state = lcg48_pkg::ST_WRITE;
                end
            end
            lcg48_pkg::ST_RANGE: n_state = lcg48_pkg::ST_WRITE;
            lcg48_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    n_state = lcg48_pkg::ST_IDLE;
                end
            end
            default: n_state = lcg48_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: ready and multiplier operand selection
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_mul_a         = r_seed[HW-1:0];
        w_mul_b         = lcg48_pkg::LCG_MULT;
        unique case (r_state)
            lcg48_pkg::ST_IDLE: o_s_axis_tready = 1'b1;
            lcg48_pkg::ST_MUL_LO: begin
                w_mul_a = r_seed[HW-1:0];
                w_mul_b = lcg48_pkg::LCG_MULT;
            end
            lcg48_pkg::ST_MUL_HI: begin
                w_mul_a = {{(2*HW-SW){1'b0}}, r_seed[SW-1:HW]};
                w_mul_b = lcg48_pkg::LCG_MULT;
            end
            lcg48_pkg::ST_RANGE: begin
                w_mul_a = r_draw;
                w_mul_b = {{(MW-lcg48_pkg::LEN_W){1'b0}}, r_len};
            end
            default: begin
                w_mul_a = r_seed[HW-1:0];
                w_mul_b = lcg48_pkg::LCG_MULT;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcg48_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // seed and sequencing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= lcg48_pkg::SEED_INIT;
            r_second <= 1'b0;
        end else begin
            unique case (r_state)
                lcg48_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_second <= 1'b0;
                        if (lcg48_pkg::t_action'(w_in_action) == lcg48_pkg::ACT_SET_SEED) begin
                            r_seed <= w_in_sval[SW-1:0];
                        end
                    end
                end
                lcg48_pkg::ST_MUL_HI: begin
                    if (r_second && r_action == lcg48_pkg::ACT_COMBINE) begin
                        r_seed <= w_seed_step ^ w_draw64[SW-1:0] ^ r_sval[SW-1:0];
                    end else begin
                        r_seed <= w_seed_step;
                    end
                    r_second <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // request payload capture and datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lcg48_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    r_action <= lcg48_pkg::t_action'(w_in_action);
                    r_sval   <= w_in_sval;
                    r_start  <= w_in_start;
                    r_len    <= w_in_len;
                    r_result <= '0;
                end
            end
            lcg48_pkg::ST_MUL_LO: begin
                r_acc <= lcg48_pkg::LCG_INC + w_mul_p[SW-1:0];
            end
            lcg48_pkg::ST_MUL_HI: begin
                r_hi   <= w_step_draw;
                r_draw <= w_step_draw;
                unique case (r_action)
                    lcg48_pkg::ACT_INT:
                        r_result <= {{(DW-HW){w_step_draw[HW-1]}}, w_step_draw};
                    lcg48_pkg::ACT_BOOL:
                        r_result <= {{(DW-1){1'b0}}, w_step_draw[lcg48_pkg::BOOL_BIT]};
                    lcg48_pkg::ACT_INT64:
                        r_result <= w_draw64;
                    default:
                        r_result <= '0;
                endcase
            end
            lcg48_pkg::ST_RANGE: begin
                r_result <= {{(DW-HW){w_range_sum[HW-1]}}, w_range_sum};
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lcg48_pkg::ST_WRITE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lcg48_pkg::ST_WRITE && w_out_free) begin
            r_out_data <= r_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // a taken request keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_axis_tready)
        else $error("request taken while previous one in progress");

    // a boolean result only ever carries bit zero
    a_bool_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcg48_pkg::ST_WRITE && r_action == lcg48_pkg::ACT_BOOL)
        |-> (r_result[DW-1:1] == '0))
        else $error("boolean result wider than one bit");

    // only two-draw requests take a second generator step
    a_second_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second && r_state == lcg48_pkg::ST_MUL_LO)
        |-> (r_action == lcg48_pkg::ACT_INT64 || r_action == lcg48_pkg::ACT_COMBINE))
        else $error("second step for a single-draw request");

    // a stored result is presented at once
    a_write_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcg48_pkg::ST_WRITE && w_out_free) |=> o_m_axis_tvalid)
        else $error("finished result not presented");

endmodule

### tb/testbench.sv
// stream testbench for the 48-bit lcg random generator with a predicting scoreboard
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 12;
    localparam int RAND_ITEMS  = 450;
    localparam logic [lcg48_pkg::ACT_W-1:0] ACT_UNUSED6 = 3'd6;
    localparam logic [lcg48_pkg::ACT_W-1:0] ACT_UNUSED7 = 3'd7;

    // mirrors the generator seed and checks every draw in order
    class draw_scoreboard;
        logic [lcg48_pkg::SEED_W-1:0] seed_copy;
        logic [lcg48_pkg::DATA_W-1:0] expected_draws[$];
        int                           errors;

        function new();
            seed_copy = lcg48_pkg::SEED_INIT;
            errors    = 0;
        endfunction

        // one lcg step, returns bits 47..16 of the new seed
        function logic [lcg48_pkg::HALF_W-1:0] lcg_draw();
            seed_copy = seed_copy
                      * {{(lcg48_pkg::SEED_W-lcg48_pkg::MULT_W){1'b0}}, lcg48_pkg::LCG_MULT}
                      + lcg48_pkg::LCG_INC;
            return seed_copy[lcg48_pkg::SEED_W-1:16];
        endfunction

        // work out the result of an accepted request and queue it
        function void note_request(logic [lcg48_pkg::ACT_W-1:0] act,
                                   logic [lcg48_pkg::DATA_W-1:0] sval,
                                   logic [lcg48_pkg::HALF_W-1:0] start,
                                   logic [lcg48_pkg::LEN_W-1:0] len);
            logic [lcg48_pkg::DATA_W-1:0] result;
            logic [lcg48_pkg::HALF_W-1:0] word;
            logic [lcg48_pkg::DATA_W-1:0] prod;
            result = '0;
            case (act)
                lcg48_pkg::ACT_INT: begin
                    word   = lcg_draw();
                    result = {{lcg48_pkg::HALF_W{word[lcg48_pkg::HALF_W-1]}}, word};
                end
                lcg48_pkg::ACT_RANGE: begin
                    word   = lcg_draw();
                    prod   = {32'd0, word} * {33'd0, len};
                    word   = start + prod[lcg48_pkg::DATA_W-1:lcg48_pkg::HALF_W];
                    result = {{lcg48_pkg::HALF_W{word[lcg48_pkg::HALF_W-1]}}, word};
                end
                lcg48_pkg::ACT_INT64: begin
                    result[lcg48_pkg::DATA_W-1:lcg48_pkg::HALF_W] = lcg_draw();
                    result[lcg48_pkg::HALF_W-1:0]                 = lcg_draw();
                end
                lcg48_pkg::ACT_BOOL: begin
                    word   = lcg_draw();
                    result = {63'd0, word[lcg48_pkg::BOOL_BIT]};
                end
                lcg48_pkg::ACT_SET_SEED: begin
                    seed_copy = sval[lcg48_pkg::SEED_W-1:0];
                end
                lcg48_pkg::ACT_COMBINE: begin
                    prod[lcg48_pkg::DATA_W-1:lcg48_pkg::HALF_W] = lcg_draw();
                    prod[lcg48_pkg::HALF_W-1:0]                 = lcg_draw();
                    seed_copy = seed_copy ^ prod[lcg48_pkg::SEED_W-1:0]
                              ^ sval[lcg48_pkg::SEED_W-1:0];
                end
                default: begin
                    // unused codes leave the seed alone and return zero
                end
            endcase
            expected_draws = {expected_draws, result};
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(logic [lcg48_pkg::DATA_W-1:0] got);
            logic [lcg48_pkg::DATA_W-1:0] want;
            if (expected_draws.size() == 0) begin
                $display("%0t: unexpected draw_value, expected none actual %h", $time, got);
                errors++;
            end else begin
                want = expected_draws.pop_front();
                if (got !== want) begin
                    $display("%0t: draw_value mismatch, expected %h actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction
    endclass

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    // action, seed_value, range_start, range_length, zero fill (lowest bit up)
    logic [lcg48_pkg::IN_DATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    // draw_value
    logic [lcg48_pkg::DATA_W-1:0]      o_m_axis_tdata;

    draw_scoreboard draw_check;
    int             send_idle_pct = 22;
    int             recv_idle_pct = 54;
    int             cycle_count   = 0;

    lcg48_random_generator_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random backpressure and checking of each transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            draw_check.check_result(o_m_axis_tdata);
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // present one request, with random gaps ahead of it, and wait for acceptance
    task automatic send_request(logic [lcg48_pkg::ACT_W-1:0] act,
                                logic [lcg48_pkg::DATA_W-1:0] sval,
                                logic [lcg48_pkg::HALF_W-1:0] start,
                                logic [lcg48_pkg::LEN_W-1:0] len);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, len, start, sval, act};
        do @(posedge i_clk); while (!o_s_axis_tready);
        draw_check.note_request(act, sval, start, len);
    endtask

    // stimulus
    initial begin
        logic [lcg48_pkg::ACT_W-1:0]  act;
        logic [lcg48_pkg::DATA_W-1:0] sval;
        logic [lcg48_pkg::HALF_W-1:0] start;
        logic [lcg48_pkg::LEN_W-1:0]  len;
        int                           pick;

        draw_check = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset seed, seed extremes, every action, range corners
        send_request(lcg48_pkg::ACT_INT,      64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_BOOL,     64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_SET_SEED, 64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_INT,      64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_SET_SEED, '1,                     32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_INT64,    64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_SET_SEED, 64'h8000_0000_0000_0000, 32'd0,        31'd0);
        send_request(lcg48_pkg::ACT_INT,      64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_SET_SEED, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0,        31'd0);
        send_request(lcg48_pkg::ACT_BOOL,     64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_RANGE,    64'd0,                  32'h8000_0000, 31'd0);
        send_request(lcg48_pkg::ACT_RANGE,    64'd0,                  32'h7FFF_FFFF, 31'd0);
        send_request(lcg48_pkg::ACT_RANGE,    64'd0,                  32'h7FFF_FFFF, '1);
        send_request(lcg48_pkg::ACT_RANGE,    64'd0,                  32'h8000_0000, '1);
        send_request(lcg48_pkg::ACT_RANGE,    64'd0,                  32'd0,         31'd1);
        send_request(lcg48_pkg::ACT_RANGE,    '1,                     '1,            31'd100);
        send_request(lcg48_pkg::ACT_COMBINE,  64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_INT64,    64'd0,                  32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_COMBINE,  '1,                     32'd0,         31'd0);
        send_request(lcg48_pkg::ACT_COMBINE,  64'h8000_0000_0000_0000, 32'd0,        31'd0);
        send_request(ACT_UNUSED6,             '1,                     '1,            '1);
        send_request(lcg48_pkg::ACT_INT,      64'd0,                  32'd0,         31'd0);
        send_request(ACT_UNUSED7,             64'h1234_5678_9ABC_DEF0, 32'd5,        31'd7);
        send_request(lcg48_pkg::ACT_INT64,    64'd0,                  32'd0,         31'd0);

        // random requests in three idling phases
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 22;
            end else if (n == 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            if      (pick < 20) act = lcg48_pkg::ACT_INT;
            else if (pick < 38) act = lcg48_pkg::ACT_RANGE;
            else if (pick < 52) act = lcg48_pkg::ACT_INT64;
            else if (pick < 66) act = lcg48_pkg::ACT_BOOL;
            else if (pick < 78) act = lcg48_pkg::ACT_SET_SEED;
            else if (pick < 94) act = lcg48_pkg::ACT_COMBINE;
            else if (pick < 97) act = ACT_UNUSED6;
            else                act = ACT_UNUSED7;
            case ($urandom_range(0, 7))
                0:       sval = '0;
                1:       sval = '1;
                2:       sval = 64'h8000_0000_0000_0000;
                3:       sval = 64'h7FFF_FFFF_FFFF_FFFF;
                default: sval = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 7))
                0:       start = 32'h8000_0000;
                1:       start = 32'h7FFF_FFFF;
                2:       start = '0;
                default: start = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       len = '0;
                1:       len = '1;
                2, 3:    len = 31'($urandom_range(1, 16));
                default: len = 31'($urandom);
            endcase
            send_request(act, sval, start, len);
        end
        i_s_axis_tvalid <= 1'b0;

        // drain outstanding results, then a short quiet window
        while (draw_check.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (draw_check.errors == 0 && draw_check.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
